FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL file qpht_back.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/qpht_pkg.sv
package qpht_pkg;

    // Fixed field widths of the item and result ports.
    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    // The key is reduced modulo the table size by a reciprocal multiply, then
    // a back-multiply and subtract.
    localparam int HASH_STEPS = 2;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        FL_EMPTY    = 2'd0,
        FL_OCCUPIED = 2'd1,
        FL_DELETED  = 2'd2
    } t_flag;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BS_CLEAR = 2'd0,
        BS_IDLE  = 2'd1,
        BS_CHECK = 2'd2
    } t_bstate;

    // One command as it travels from the front to the back.
    typedef struct packed {
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_item;

    // One slot of the table store.
    typedef struct packed {
        t_flag            flag;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

endpackage

FILE: rtl/quadratic_probe_hash_table_top.sv
// Open-addressing hash table with quadratic probing, key to value.
// Input channel (i_valid / o_stall): one item is an insert-or-update
// (i_cmd = 0, with i_value) or a remove (i_cmd = 1) of i_key.
// Output channel (o_valid / i_stall): exactly one result per item, in order:
// o_status, the slot touched (zero on full or not found) and the number of
// occupied slots after the operation.
// The front reduces the key modulo TABLE_SIZE by a reciprocal multiply and
// then a back-multiply and subtract, and then hands the item on; it holds
// one item at a time.
// A two-entry queue sits between the front and the probe sequencer.
// The back reads the home slot and then checks one slot of the memory per
// probe, 1 to TABLE_SIZE probes, the store write-back, if any, happening
// when the last probe commits. It holds one item at a time and takes the
// next only once the last has committed.
// After reset a clearing pass marks every slot empty, one per cycle, while
// o_stall stays high.
// When the receiver stalls, the result waits in the output register; the
// back finishes its next item up to the write-back and waits, the queue
// and the front fill, and then o_stall rises.
module quadratic_probe_hash_table_top #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_cmd,
    input  logic [qpht_pkg::KEY_W-1:0]         i_key,
    input  logic signed [qpht_pkg::VAL_W-1:0]  i_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [qpht_pkg::STATUS_W-1:0]      o_status,
    output logic [qpht_pkg::SLOT_W-1:0]        o_slot,
    output logic [qpht_pkg::COUNT_W-1:0]       o_entry_count
);

    import qpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int ITEM_W = $bits(t_item);
    localparam int Q_W = IDX_W + ITEM_W;

    t_item            in_item;
    t_item            f_item;
    logic [IDX_W-1:0] f_home;
    logic             f_valid;
    logic             f_stall;
    logic [Q_W-1:0]   q_data;
    logic             q_valid;
    logic             q_stall;
    t_item            q_item;
    logic [IDX_W-1:0] q_home;
    logic             clearing;
    t_status          b_status;

    assign in_item = '{cmd: t_cmd'(i_cmd), key: i_key, value: i_value};

    qpht_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (clearing),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (in_item),
        .o_valid (f_valid),
        .i_stall (f_stall),
        .o_item  (f_item),
        .o_home  (f_home)
    );

    qpht_fifo #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_stall (f_stall),
        .i_data  ({f_home, f_item}),
        .o_valid (q_valid),
        .i_stall (q_stall),
        .o_data  (q_data)
    );

    assign q_home = q_data[Q_W-1 -: IDX_W];
    assign q_item = t_item'(q_data[ITEM_W-1:0]);

    qpht_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_clearing    (clearing),
        .i_valid       (q_valid),
        .o_stall       (q_stall),
        .i_item        (q_item),
        .i_home        (q_home),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (b_status),
        .o_slot        (o_slot),
        .o_entry_count (o_entry_count)
    );

    assign o_status = b_status;

endmodule

FILE: rtl/qpht_ram.sv
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/qpht_front.sv
module qpht_front #(
    parameter int TABLE_SIZE = 16,
    localparam int IDX_W = $clog2(TABLE_SIZE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_hold,
    input  logic               i_valid,
    output logic               o_stall,
    input  qpht_pkg::t_item    i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output qpht_pkg::t_item    o_item,
    output logic [IDX_W-1:0]   o_home
);

    import qpht_pkg::*;

    localparam int STEP_W  = $clog2(HASH_STEPS);
    localparam int MAGIC_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + MAGIC_W;
    localparam int SHIFT   = KEY_W + IDX_W;
    // Rounded-up reciprocal of the table size, exact for every key value.
    localparam logic [MAGIC_W-1:0] MAGIC =
        MAGIC_W'(((64'd1 << SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
    localparam logic [IDX_W-1:0] SIZE_LOW = IDX_W'(TABLE_SIZE);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [IDX_W-1:0]      r_quot;
    logic [IDX_W-1:0]      r_rem;
    t_item                 r_item;
    logic [PROD_W-1:0]     prod;
    logic [IDX_W-1:0]      quot;
    logic [IDX_W-1:0]      n_rem;
    logic                  take;
    logic                  push;

    assign o_stall = r_busy || i_hold;
    assign take    = i_valid && !o_stall;
    assign push    = r_done && !i_stall;

    // Quotient from the reciprocal; only its low bits matter for the remainder.
    assign prod  = PROD_W'(r_item.key) * PROD_W'(MAGIC);
    assign quot  = prod[SHIFT +: IDX_W];
    // The remainder is below the table size, so its low bits are all it needs.
    assign n_rem = r_item.key[IDX_W-1:0] - r_quot * SIZE_LOW;

    // Control: one item is hashed at a time, then handed to the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (push) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (r_busy && !r_done) begin
            r_step <= r_step + STEP_W'(1);
            if (r_step == STEP_W'(HASH_STEPS - 1)) begin
                r_done <= 1'b1;
            end
        end
    end

    // Payload: the item, the quotient and the remainder.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
            r_quot <= '0;
            r_rem  <= '0;
        end else if (r_busy && !r_done) begin
            r_quot <= quot;
            r_rem  <= n_rem;
        end
    end

    assign o_valid = r_done;
    assign o_item  = r_item;
    assign o_home  = r_rem;

endmodule

FILE: rtl/qpht_fifo.sv
module qpht_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              push;
    logic              pop;

    assign o_stall = (r_fill == FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    // Storage of the queued items.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/qpht_back.sv
module qpht_back #(
    parameter int TABLE_SIZE = 16,
    localparam int IDX_W = $clog2(TABLE_SIZE)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    output logic                                o_clearing,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  qpht_pkg::t_item                     i_item,
    input  logic [IDX_W-1:0]                    i_home,
    output logic                                o_valid,
    input  logic                                i_stall,
    output qpht_pkg::t_status                   o_status,
    output logic [qpht_pkg::SLOT_W-1:0]         o_slot,
    output logic [qpht_pkg::COUNT_W-1:0]        o_entry_count
);

    import qpht_pkg::*;

    `include "assert_macros.svh"

    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int ENT_W = $bits(t_entry);
    localparam logic [IDX_W:0] MOD = (IDX_W + 1)'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    // Square of the first probe step and the first odd increment.
    localparam logic [IDX_W-1:0] SQ0 = IDX_W'(1 % TABLE_SIZE);
    localparam logic [IDX_W-1:0] D0  = IDX_W'(3 % TABLE_SIZE);

    t_bstate             r_state;
    t_bstate             n_state;
    logic [IDX_W-1:0]    r_clr_addr;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    t_cmd                r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [VAL_W-1:0]    r_value;
    logic [IDX_W-1:0]    r_home;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_sq;
    logic [IDX_W-1:0]    r_d;
    logic [IDX_W-1:0]    r_n;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [COUNT_W-1:0]  r_out_count;

    logic [IDX_W-1:0]    nxt_idx;
    logic [IDX_W-1:0]    nxt_sq;
    logic [IDX_W-1:0]    nxt_d;
    logic                last;
    logic                key_hit;
    logic                finish;
    logic                success;
    logic                commit;
    logic                pop;
    logic                out_take;
    logic                out_free;
    logic                clr_last;
    t_status             res_status;
    logic [IDX_W-1:0]    res_slot;
    logic [31:0]         slot_ext;
    logic [31:0]         count_ext;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;
    t_entry              rd_entry;

    qpht_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry   = t_entry'(ram_rdata);
    assign key_hit    = (rd_entry.key == r_key);
    assign out_take   = r_out_valid && !i_stall;
    assign out_free   = !r_out_valid || out_take;
    assign clr_last   = (r_clr_addr == LAST_IDX);
    assign o_clearing = (r_state == BS_CLEAR);
    assign o_stall    = (r_state != BS_IDLE);

    // Next probe index: add the running square, then its next value.
    always_comb begin
        logic [IDX_W:0] sum_idx;
        logic [IDX_W:0] sum_sq;
        logic [IDX_W:0] sum_d;
        sum_idx = {1'b0, r_idx} + {1'b0, r_sq};
        if (sum_idx >= MOD) begin
            sum_idx = sum_idx - MOD;
        end
        sum_sq = {1'b0, r_sq} + {1'b0, r_d};
        if (sum_sq >= MOD) begin
            sum_sq = sum_sq - MOD;
        end
        sum_d = {1'b0, r_d} + (IDX_W + 1)'(2);
        if (sum_d >= MOD) begin
            sum_d = sum_d - MOD;
        end
        nxt_idx = sum_idx[IDX_W-1:0];
        nxt_sq  = sum_sq[IDX_W-1:0];
        nxt_d   = sum_d[IDX_W-1:0];
    end

    // The probe ends after the last allowed step or back at the home slot.
    assign last = (r_n == LAST_IDX) || (nxt_idx == r_home);

    // Next state of the probe sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR: begin
                if (clr_last) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_valid) begin
                    n_state = BS_CHECK;
                end
            end
            BS_CHECK: begin
                if (commit) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Slot decisions, store writes and the read address of the next probe.
    always_comb begin
        ram_raddr  = r_idx;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = '{flag: FL_OCCUPIED, key: r_key, value: r_value};
        pop        = 1'b0;
        commit     = 1'b0;
        finish     = 1'b0;
        success    = 1'b0;
        res_status = ST_NOT_FOUND;
        res_slot   = '0;
        n_count    = r_count;
        case (r_state)
            BS_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '{flag: FL_EMPTY, key: '0, value: '0};
            end
            BS_IDLE: begin
                pop       = i_valid;
                ram_raddr = i_home;
            end
            BS_CHECK: begin
                if (r_cmd == CMD_INSERT) begin
                    if (rd_entry.flag != FL_OCCUPIED) begin
                        success    = 1'b1;
                        res_status = ST_INSERTED;
                        n_count    = r_count + CNT_W'(1);
                    end else if (key_hit) begin
                        success    = 1'b1;
                        res_status = ST_UPDATED;
                    end else begin
                        res_status = ST_FULL;
                    end
                    finish = success || last;
                end else begin
                    // A remove keeps the stored key and value and marks the slot.
                    if (rd_entry.flag == FL_OCCUPIED && key_hit) begin
                        success    = 1'b1;
                        res_status = ST_REMOVED;
                        ram_wdata  = '{flag: FL_DELETED, key: rd_entry.key,
                                       value: rd_entry.value};
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    finish = success || (rd_entry.flag == FL_EMPTY) || last;
                end
                if (success) begin
                    res_slot = r_idx;
                end
                commit    = finish && out_free;
                ram_we    = commit && success;
                ram_raddr = finish ? r_idx : nxt_idx;
            end
            default: ;
        endcase
    end

    assign slot_ext  = 32'(res_slot);
    assign count_ext = 32'(n_count);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command and probe registers.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd   <= i_item.cmd;
            r_key   <= i_item.key;
            r_value <= i_item.value;
            r_home  <= i_home;
            r_idx   <= i_home;
            r_sq    <= SQ0;
            r_d     <= D0;
            r_n     <= '0;
        end else if (r_state == BS_CHECK && !finish) begin
            r_idx <= nxt_idx;
            r_sq  <= nxt_sq;
            r_d   <= nxt_d;
            r_n   <= r_n + IDX_W'(1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_status <= res_status;
            r_out_slot   <= slot_ext[SLOT_W-1:0];
            r_out_count  <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_slot        = r_out_slot;
    assign o_entry_count = r_out_count;

    // The occupied count never passes the table size.
    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(TABLE_SIZE), "count overflow")
    // The probe index stays inside the table.
    `ASSERT_CLK(a_idx_range, i_clk, i_rst_n, (r_state == BS_CHECK) |-> (r_idx <= LAST_IDX), "probe index out of range")
    // A finished command always leaves a result waiting.
    `ASSERT_CLK(a_commit_out, i_clk, i_rst_n, commit |=> r_out_valid, "result lost")
    // No command is taken from the queue during the clearing pass.
    `ASSERT_ALWAYS(a_no_pop_clear, i_clk, (r_state == BS_CLEAR) |-> !pop, "pop while clearing")

endmodule

FILE: tb/quadratic_probe_hash_table_top_tb.sv
module quadratic_probe_hash_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qpht_pkg::*;

    localparam int TABLE_SIZE     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int HOLD_LONG      = 400;
    localparam int KEY_POOL_SIZE  = 6;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

    // One result as the block should report it.
    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count;
    } t_table_result;

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic                      i_cmd   = 1'b0;
    logic [KEY_W-1:0]          i_key   = '0;
    logic signed [VAL_W-1:0]   i_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic [SLOT_W-1:0]         o_slot;
    logic [COUNT_W-1:0]        o_entry_count;

    // Shadow copy of the table contents.
    t_flag                     tbl_flag [TABLE_SIZE];
    logic [KEY_W-1:0]          tbl_key  [TABLE_SIZE];
    logic [VAL_W-1:0]          tbl_val  [TABLE_SIZE];
    int                        tbl_count;

    t_table_result             pending_results [$];
    logic [KEY_W-5:0]          key_hi_pool [KEY_POOL_SIZE];
    int                        error_count = 0;
    int                        report_count = 0;
    bit                        tx_idle_en = 1'b1;
    bit                        rx_idle_en = 1'b1;
    int                        rx_hold_request = 0;

    quadratic_probe_hash_table_top #(
        .TABLE_SIZE(TABLE_SIZE)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd(i_cmd),
        .i_key(i_key),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_slot(o_slot),
        .o_entry_count(o_entry_count)
    );

    always #2 i_clk = ~i_clk;

    // Apply one operation to the shadow table and return the result it yields.
    function automatic t_table_result apply_table_op(input t_cmd cmd,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [VAL_W-1:0] value);
        t_table_result res;
        int home;
        int idx;
        int h;
        bit done;
        home = int'(key % TABLE_SIZE);
        idx = home;
        h = 1;
        done = 1'b0;
        res.status = (cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
        res.slot = '0;
        for (int n = 0; n < TABLE_SIZE && !done; n++) begin
            if (cmd == CMD_INSERT) begin
                if (tbl_flag[idx] != FL_OCCUPIED) begin
                    tbl_flag[idx] = FL_OCCUPIED;
                    tbl_key[idx] = key;
                    tbl_val[idx] = value;
                    tbl_count++;
                    res.status = ST_INSERTED;
                    res.slot = SLOT_W'(idx);
                    done = 1'b1;
                end else if (tbl_key[idx] == key) begin
                    tbl_val[idx] = value;
                    res.status = ST_UPDATED;
                    res.slot = SLOT_W'(idx);
                    done = 1'b1;
                end
            end else begin
                // A remove gives up as soon as it meets an empty slot.
                if (tbl_flag[idx] == FL_EMPTY) begin
                    done = 1'b1;
                end else if (tbl_flag[idx] == FL_OCCUPIED && tbl_key[idx] == key) begin
                    tbl_flag[idx] = FL_DELETED;
                    if (tbl_count > 0) tbl_count--;
                    res.status = ST_REMOVED;
                    res.slot = SLOT_W'(idx);
                    done = 1'b1;
                end
            end
            // Quadratic step; the walk also ends when it comes back home.
            if (!done) begin
                idx = (idx + h * h) % TABLE_SIZE;
                h++;
                if (idx == home) done = 1'b1;
            end
        end
        res.count = COUNT_W'(tbl_count);
        return res;
    endfunction

    // Offer one item after a random gap and wait until the block takes it.
    task automatic send_item(input t_cmd cmd, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] value);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_key   <= key;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(apply_table_op(cmd, key, value));
    endtask

    // Random operation on keys that mostly collide on a few home slots.
    task automatic send_random_op(input int insert_pct);
        t_cmd cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [3:0] home;
        int pick;
        cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        if ($urandom_range(0, 99) < 10) begin
            key = KEY_W'($urandom);
        end else begin
            home = $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(0, 2));
            key = {key_hi_pool[$urandom_range(0, KEY_POOL_SIZE - 1)], home};
        end
        pick = $urandom_range(0, 99);
        case (pick)
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'h0000_0000;
            3: value = 32'hFFFF_FFFF;
            default: value = $urandom;
        endcase
        send_item(cmd, key, value);
    endtask

    task automatic test_directed_cases;
        send_item(CMD_INSERT, '0, 32'h7FFF_FFFF);
        send_item(CMD_INSERT, KEY_MAX, 32'h8000_0000);
        // Same key again updates in place.
        send_item(CMD_INSERT, '0, 32'h0000_0000);
        // Remove with an empty home slot.
        send_item(CMD_REMOVE, 31'd5, 32'hFFFF_FFFF);
        send_item(CMD_REMOVE, KEY_MAX, 32'h0);
        // Walks past the deleted slot and stops at an empty one.
        send_item(CMD_REMOVE, KEY_MAX, 32'h0);
        // Keys sharing home slot 0 fill its probe path; the last reports full.
        for (int k = 1; k <= 11; k++) begin
            send_item(CMD_INSERT, KEY_W'(16 * k), $urandom);
        end
        // No empty slot left on the path, so the remove runs to the probe cap.
        send_item(CMD_REMOVE, 31'd192, $urandom);
        // A deleted slot ahead of a stored key lets that key be stored twice.
        send_item(CMD_REMOVE, 31'd16, $urandom);
        send_item(CMD_INSERT, 31'd32, $urandom);
        send_item(CMD_REMOVE, 31'd32, $urandom);
        send_item(CMD_REMOVE, 31'd32, $urandom);
    endtask

    task automatic test_probe_collisions;
        int insert_pct;
        for (int phase = 0; phase < 13; phase++) begin
            case ($urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 30;
                default: insert_pct = 55;
            endcase
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat (100) send_random_op(insert_pct);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_back_to_back;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (300) send_random_op(60);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_backpressure;
        // Receiver holds off while items keep coming, until the input stalls.
        tx_idle_en = 1'b0;
        rx_hold_request = HOLD_LONG;
        repeat (60) send_random_op(60);
        tx_idle_en = 1'b1;
        repeat (240) send_random_op(55);
    endtask

    // Compare each accepted result with the oldest expectation; drive i_stall.
    initial begin : result_checker
        t_table_result want;
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("unexpected result: status %0d slot %0d count %0d",
                                 o_status, o_slot, o_entry_count);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (o_status != want.status || o_slot != want.slot ||
                            o_entry_count != want.count) begin
                        error_count++;
                        if (report_count < MAX_REPORTS) begin
                            report_count++;
                            $display("mismatch (status/slot/count): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.status, want.slot, want.count,
                                     o_status, o_slot, o_entry_count);
                        end
                    end
                end
            end
            if (rx_hold_request > 0) begin
                hold = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if (o_valid && !i_stall && rx_idle_en) begin
                hold = $urandom_range(0, 18);
                if (hold > 0) begin
                    hold--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // End the run if neither channel moves an item for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : main_sequence
        for (int i = 0; i < TABLE_SIZE; i++) begin
            tbl_flag[i] = FL_EMPTY;
            tbl_key[i]  = '0;
            tbl_val[i]  = '0;
        end
        tbl_count = 0;
        key_hi_pool[0] = '0;
        key_hi_pool[1] = 27'd1;
        key_hi_pool[2] = 27'd2;
        key_hi_pool[3] = {27{1'b1}};
        key_hi_pool[4] = 27'($urandom);
        key_hi_pool[5] = 27'($urandom);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_probe_collisions();
        test_back_to_back();
        test_output_backpressure();
        i_valid <= 1'b0;

        // Let every outstanding result come back, then a short quiet spell.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
